>>> rtl/vsl_pkg.sv
// ----------------------------------------------------------------------------
// vsl_pkg
// shared constants, types and helpers of the vga scanout line ring
// ----------------------------------------------------------------------------
`default_nettype none

package vsl_pkg;

	localparam int RING_SLOTS  = 4;
	localparam int LINE_PIXELS = 1024;
	localparam int STORE_DEPTH = RING_SLOTS * LINE_PIXELS;

	localparam int SLOT_W = $clog2(RING_SLOTS);
	localparam int COL_W  = $clog2(LINE_PIXELS);
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W  = 11;
	localparam int LEN_W  = 12;
	localparam int CFG_W  = 11;
	localparam int LINE_W = 10;
	localparam int V_VIS_MAX = 1024;

	// pin bytes: bit7 vsync, bit6 hsync, both idle high
	localparam logic [7:0] BYTE_IDLE = 8'hC0;
	localparam logic [7:0] BYTE_HS   = 8'h80;
	localparam logic [7:0] BYTE_VS   = 8'h40;
	localparam logic [7:0] BYTE_HSVS = 8'h00;

	// register indexes
	localparam logic [2:0] REG_H_SYNC  = 3'd0;
	localparam logic [2:0] REG_H_BACK  = 3'd1;
	localparam logic [2:0] REG_H_VIS   = 3'd2;
	localparam logic [2:0] REG_H_FRONT = 3'd3;
	localparam logic [2:0] REG_V_SYNC  = 3'd4;
	localparam logic [2:0] REG_V_BACK  = 3'd5;
	localparam logic [2:0] REG_V_VIS   = 3'd6;
	localparam logic [2:0] REG_V_FRONT = 3'd7;

	// per-tick decode handed from the timing unit to the pipeline
	typedef struct packed {
		logic              sel_mem;
		logic [7:0]        const_byte;
		logic [ADDR_W-1:0] rd_addr;
		logic              request;
		logic [CNT_W-1:0]  fill_base;
		logic [SLOT_W-1:0] fill_slot;
		logic [CNT_W-1:0]  vv_len;
	} tick_info_t;

	// (v + RING_SLOTS) mod vv, with v < vv and vv >= 1
	function automatic logic [LINE_W-1:0] fill_wrap(input logic [CNT_W-1:0] x,
			input logic [CNT_W-1:0] m);
		logic [CNT_W-1:0] r;
		r = x;
		for (int i = 0; i < RING_SLOTS; i++) begin
			if (r >= m) begin
				r = r - m;
			end
		end
		return r[LINE_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/vsl_line_store.sv
// ----------------------------------------------------------------------------
// vsl_line_store
// ring of line buffers: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module vsl_line_store (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [vsl_pkg::ADDR_W-1:0] waddr,
	input  wire logic [7:0]                wdata,
	input  wire logic                      re,
	input  wire logic [vsl_pkg::ADDR_W-1:0] raddr,
	output logic      [7:0]                rdata
);

	logic [7:0] mem [vsl_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/vsl_timing.sv
// ----------------------------------------------------------------------------
// vsl_timing
// timing registers, pixel and line counters and per-tick region decode
// ----------------------------------------------------------------------------
`default_nettype none

module vsl_timing (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [vsl_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      step,
	output vsl_pkg::tick_info_t            info
);

	localparam int CW = vsl_pkg::CNT_W;
	localparam int LW = vsl_pkg::LEN_W;

	logic [7:0]    h_sync_q, h_back_q, h_front_q;
	logic [CW-1:0] h_vis_q, v_vis_q;
	logic [3:0]    v_sync_q;
	logic [5:0]    v_back_q, v_front_q;
	logic [CW-1:0] pix_q, line_q;

	logic [CW-1:0] hv, vv;
	logic [LW-1:0] vis_start, vis_end, line_len;
	logic [LW-1:0] act_start, act_end, frame_len;
	logic [LW-1:0] p, l, p_inc, l_inc, vline, col;
	logic          vsync_line, vis_line, hsync, in_vis, last;
	logic [vsl_pkg::SLOT_W-1:0] slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_sync_q  <= 8'd96;
			h_back_q  <= 8'd48;
			h_vis_q   <= 11'd640;
			h_front_q <= 8'd16;
			v_sync_q  <= 4'd2;
			v_back_q  <= 6'd33;
			v_vis_q   <= 11'd480;
			v_front_q <= 6'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				vsl_pkg::REG_H_SYNC:  h_sync_q  <= cfg_data[7:0];
				vsl_pkg::REG_H_BACK:  h_back_q  <= cfg_data[7:0];
				vsl_pkg::REG_H_VIS:   h_vis_q   <= cfg_data;
				vsl_pkg::REG_H_FRONT: h_front_q <= cfg_data[7:0];
				vsl_pkg::REG_V_SYNC:  v_sync_q  <= cfg_data[3:0];
				vsl_pkg::REG_V_BACK:  v_back_q  <= cfg_data[5:0];
				vsl_pkg::REG_V_VIS:   v_vis_q   <= cfg_data;
				vsl_pkg::REG_V_FRONT: v_front_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// zero length acts as one, clamp to store width / line limit
		if (h_vis_q == '0) begin
			hv = CW'(1);
		end else if (h_vis_q > CW'(vsl_pkg::LINE_PIXELS)) begin
			hv = CW'(vsl_pkg::LINE_PIXELS);
		end else begin
			hv = h_vis_q;
		end
		if (v_vis_q == '0) begin
			vv = CW'(1);
		end else if (v_vis_q > CW'(vsl_pkg::V_VIS_MAX)) begin
			vv = CW'(vsl_pkg::V_VIS_MAX);
		end else begin
			vv = v_vis_q;
		end

		vis_start = LW'(h_sync_q) + LW'(h_back_q);
		vis_end   = vis_start + LW'(hv);
		line_len  = vis_end + LW'(h_front_q);
		act_start = LW'(v_sync_q) + LW'(v_back_q);
		act_end   = act_start + LW'(vv);
		frame_len = act_end + LW'(v_front_q);

		p     = LW'(pix_q);
		l     = LW'(line_q);
		p_inc = p + LW'(1);
		l_inc = l + LW'(1);
		vline = l - act_start;
		col   = p - vis_start;
		slot  = vsl_pkg::SLOT_W'(vline % LW'(vsl_pkg::RING_SLOTS));

		vsync_line = l < LW'(v_sync_q);
		vis_line   = (l >= act_start) && (l < act_end);
		hsync      = p < LW'(h_sync_q);
		in_vis     = vis_line && (p >= vis_start) && (p < vis_end);
		last       = p_inc >= line_len;

		info.sel_mem = 1'b0;
		if (hsync) begin
			info.const_byte = vsync_line ? vsl_pkg::BYTE_HSVS : vsl_pkg::BYTE_HS;
		end else if (vsync_line) begin
			info.const_byte = vsl_pkg::BYTE_VS;
		end else begin
			info.const_byte = vsl_pkg::BYTE_IDLE;
			info.sel_mem    = in_vis;
		end
		info.rd_addr = vsl_pkg::ADDR_W'(vsl_pkg::ADDR_W'(slot)
			* vsl_pkg::ADDR_W'(vsl_pkg::LINE_PIXELS) + vsl_pkg::ADDR_W'(col));
		info.request   = last && vis_line;
		info.fill_base = CW'(vline) + CW'(vsl_pkg::RING_SLOTS);
		info.fill_slot = slot;
		info.vv_len    = vv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q  <= '0;
			line_q <= '0;
		end else if (step) begin
			if (last) begin
				pix_q  <= '0;
				line_q <= (l_inc >= frame_len) ? '0 : CW'(l_inc);
			end else begin
				pix_q <= CW'(p_inc);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/vga_scanout_line_ring.sv
// ----------------------------------------------------------------------------
// vga_scanout_line_ring
// vga scanout byte generator fed from a ring of line buffers in one memory
// ----------------------------------------------------------------------------
// path: a tick beat passes stage 1 (store read), then the output register
// throughput: one beat per cycle when not clearing or stalled, ticks and
// pixel writes mixed freely; line store rate: one read and one write per cycle
// reset: timing registers to 640x480 defaults, counters to zero, then a
// clearing pass writes 0xC0 into all 4096 store entries while in_ready
// stays low; config writes are taken throughout
`default_nettype none

module vga_scanout_line_ring (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// config write port
	input  wire logic                      cfg_we,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [vsl_pkg::CFG_W-1:0] cfg_data,
	// input channel
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      kind,
	input  wire logic [1:0]                slot,
	input  wire logic [9:0]                column,
	input  wire logic [7:0]                pixel,
	// result channel
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [7:0]                out_byte,
	output logic                           fill_request,
	output logic      [9:0]                fill_line,
	output logic      [1:0]                fill_slot
);

	localparam int AW = vsl_pkg::ADDR_W;

	vsl_pkg::tick_info_t info;

	// clearing pass after reset
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	// handshake
	logic accept, tick, pix_wr, advance;

	// store ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [7:0]    rd_data;
	logic          wr_ok;

	// stage 1: store read in flight
	logic                       valid_s1;
	logic                       sel_mem_s1;
	logic [7:0]                 const_s1;
	logic                       req_s1;
	logic [vsl_pkg::CNT_W-1:0]  base_s1;
	logic [vsl_pkg::SLOT_W-1:0] slot_s1;

	// output register
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        req_q;
	logic [9:0]  fline_q;
	logic [1:0]  fslot_q;

	// output register frees when empty or when its beat is taken
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !clearing_q && (!valid_s1 || advance);
	assign accept   = in_valid && in_ready;
	assign tick     = accept && !kind;
	assign pix_wr   = accept && kind;

	vsl_timing u_timing (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (tick),
		.info      (info)
	);

	// writes out of store range are dropped
	assign wr_ok = (32'(slot) < 32'(vsl_pkg::RING_SLOTS))
		&& (32'(column) < 32'(vsl_pkg::LINE_PIXELS));

	// clearing pass owns the write port; no beat is accepted meanwhile.
	// a write lands at its accept edge, so a later tick always reads it
	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = vsl_pkg::BYTE_IDLE;
		end else begin
			mem_we    = pix_wr && wr_ok;
			mem_waddr = AW'(AW'(slot) * AW'(vsl_pkg::LINE_PIXELS) + AW'(column));
			mem_wdata = pixel;
		end
	end

	vsl_line_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (tick),
		.raddr (info.rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(vsl_pkg::STORE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// stage 1 control; read data holds while stalled since no new tick enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			sel_mem_s1 <= info.sel_mem;
			const_s1   <= info.const_byte;
			req_s1     <= info.request;
			base_s1    <= info.fill_base;
			slot_s1    <= info.fill_slot;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// fill fields read zero when no refill is requested
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			byte_q  <= sel_mem_s1 ? rd_data : const_s1;
			req_q   <= req_s1;
			fline_q <= req_s1 ? vsl_pkg::fill_wrap(base_s1, info.vv_len) : '0;
			fslot_q <= req_s1 ? 2'(slot_s1) : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = byte_q;
	assign fill_request = req_q;
	assign fill_line    = fline_q;
	assign fill_slot    = fslot_q;

endmodule

`default_nettype wire
